>>> design/iqf_pkg.sv
package iqf_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int TABLE_LEN = 24;

	localparam int IN_W = 16;
	localparam int PRESCALE_SH = 8;
	localparam int XW = 27;
	localparam int ZW = 32;
	localparam int PW = 16;
	localparam int FW = 17;
	localparam int DW = 18;

	localparam logic [ZW-1:0] Z_QUARTER = 32'h4000_0000;
	localparam logic [ZW-1:0] Z_THREE_QUARTER = 32'hC000_0000;
	localparam logic [ZW-1:0] Z_ROUND = 32'h0000_8000;

	localparam logic [ZW-1:0] ATAN_TURNS [TABLE_LEN] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	localparam logic signed [DW-1:0] HALF_TURN = 18'sd32768;
	localparam logic signed [DW-1:0] FULL_TURN = 18'sd65536;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic [ZW-1:0] z;
		logic zero;
		logic last;
	} cordic_t;

	typedef struct packed {
		logic [PW-1:0] phase;
		logic last;
	} phase_item_t;

endpackage

>>> design/iqf_iq_if.sv
interface iqf_iq_if;
	logic valid;
	logic ready;
	logic signed [iqf_pkg::IN_W-1:0] i_sample;
	logic signed [iqf_pkg::IN_W-1:0] q_sample;
	logic frame_last;

	modport source(output valid, output i_sample, output q_sample, output frame_last,
		input ready);
	modport sink(input valid, input i_sample, input q_sample, input frame_last,
		output ready);
endinterface

>>> design/iqf_res_if.sv
interface iqf_res_if;
	logic valid;
	logic ready;
	logic signed [iqf_pkg::FW-1:0] freq_turns;
	logic frame_end;

	modport source(output valid, output freq_turns, output frame_end, input ready);
	modport sink(input valid, input freq_turns, input frame_end, output ready);
endinterface

>>> design/iqf_cordic_stage.sv
module iqf_cordic_stage #(
	parameter int STEP = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_in,
	input  iqf_pkg::cordic_t d_in,
	output logic             vld_s1,
	output iqf_pkg::cordic_t d_s1
);

	iqf_pkg::cordic_t nxt;
	logic signed [iqf_pkg::XW-1:0] xs;
	logic signed [iqf_pkg::XW-1:0] ys;

	always_comb begin
		xs = $signed(d_in.x) >>> STEP;
		ys = $signed(d_in.y) >>> STEP;
		nxt = d_in;
		if (!d_in.y[iqf_pkg::XW-1]) begin
			nxt.x = d_in.x + ys;
			nxt.y = d_in.y - xs;
			nxt.z = d_in.z + iqf_pkg::ATAN_TURNS[STEP];
		end else begin
			nxt.x = d_in.x - ys;
			nxt.y = d_in.y + xs;
			nxt.z = d_in.z - iqf_pkg::ATAN_TURNS[STEP];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= nxt;
		end
	end

endmodule

>>> design/iqf_phase.sv
module iqf_phase #(
	parameter int CORDIC_STEPS = iqf_pkg::CORDIC_STEPS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	iqf_iq_if.sink               iq,
	input  logic                 can_take,
	output logic                 tail_vld,
	output iqf_pkg::phase_item_t tail
);

	localparam int STEPS = (CORDIC_STEPS > iqf_pkg::TABLE_LEN) ?
		iqf_pkg::TABLE_LEN : CORDIC_STEPS;
	localparam int EXT_W = iqf_pkg::XW - iqf_pkg::IN_W - iqf_pkg::PRESCALE_SH;

	logic en;
	logic signed [iqf_pkg::XW-1:0] xi;
	logic signed [iqf_pkg::XW-1:0] yi;
	iqf_pkg::cordic_t pre;
	iqf_pkg::cordic_t pre_s1;
	logic pre_vld_s1;
	logic chain_vld [STEPS+1];
	iqf_pkg::cordic_t chain_d [STEPS+1];
	logic [iqf_pkg::ZW-1:0] zsum;

	assign en = !tail_vld || can_take;
	assign iq.ready = en;

	always_comb begin
		xi = {{EXT_W{iq.i_sample[iqf_pkg::IN_W-1]}}, iq.i_sample,
			{iqf_pkg::PRESCALE_SH{1'b0}}};
		yi = {{EXT_W{iq.q_sample[iqf_pkg::IN_W-1]}}, iq.q_sample,
			{iqf_pkg::PRESCALE_SH{1'b0}}};
		pre.zero = (iq.i_sample == '0) && (iq.q_sample == '0);
		pre.last = iq.frame_last;
		pre.x = xi;
		pre.y = yi;
		pre.z = '0;
		if (xi[iqf_pkg::XW-1]) begin
			if (!yi[iqf_pkg::XW-1]) begin
				pre.x = yi;
				pre.y = -xi;
				pre.z = iqf_pkg::Z_QUARTER;
			end else begin
				pre.x = -yi;
				pre.y = xi;
				pre.z = iqf_pkg::Z_THREE_QUARTER;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_vld_s1 <= 1'b0;
		end else if (en) begin
			pre_vld_s1 <= iq.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pre_s1 <= pre;
		end
	end

	assign chain_vld[0] = pre_vld_s1;
	assign chain_d[0] = pre_s1;

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		iqf_cordic_stage #(
			.STEP(k)
		) u_stage (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.vld_in(chain_vld[k]),
			.d_in  (chain_d[k]),
			.vld_s1(chain_vld[k+1]),
			.d_s1  (chain_d[k+1])
		);
	end

	always_comb begin
		zsum = chain_d[STEPS].z + iqf_pkg::Z_ROUND;
		tail_vld = chain_vld[STEPS];
		tail.last = chain_d[STEPS].last;
		tail.phase = chain_d[STEPS].zero ? '0 : zsum[iqf_pkg::ZW-1 -: iqf_pkg::PW];
	end

endmodule

>>> design/iqf_emit.sv
module iqf_emit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tail_vld,
	input  iqf_pkg::phase_item_t tail,
	output logic                 can_take,
	iqf_res_if.source            res
);

	logic take;
	logic vld_q;
	logic pend_q;
	logic have_prev_q;
	logic [iqf_pkg::PW-1:0] prev_phase_q;
	logic signed [iqf_pkg::FW-1:0] freq_q;
	logic fend_q;
	logic signed [iqf_pkg::DW-1:0] raw;
	logic signed [iqf_pkg::DW-1:0] wrapped;

	always_comb begin
		can_take = !pend_q && (!vld_q || res.ready);
		take = tail_vld && can_take;
		raw = $signed({{(iqf_pkg::DW-iqf_pkg::PW){tail.phase[iqf_pkg::PW-1]}}, tail.phase})
			- $signed({{(iqf_pkg::DW-iqf_pkg::PW){prev_phase_q[iqf_pkg::PW-1]}},
			prev_phase_q});
		wrapped = raw;
		if (raw > iqf_pkg::HALF_TURN) begin
			wrapped = raw - iqf_pkg::FULL_TURN;
		end else if (raw < -iqf_pkg::HALF_TURN) begin
			wrapped = raw + iqf_pkg::FULL_TURN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			pend_q <= 1'b0;
			have_prev_q <= 1'b0;
			prev_phase_q <= '0;
		end else if (take) begin
			vld_q <= have_prev_q || tail.last;
			pend_q <= have_prev_q && tail.last;
			have_prev_q <= !tail.last;
			prev_phase_q <= tail.phase;
		end else if (vld_q && res.ready) begin
			vld_q <= pend_q;
			pend_q <= 1'b0;
		end
	end

	// hold the closing zero behind a step result
	always_ff @(posedge clk) begin
		if (take) begin
			freq_q <= have_prev_q ? wrapped[iqf_pkg::FW-1:0] : '0;
			fend_q <= !have_prev_q && tail.last;
		end else if (pend_q && res.ready) begin
			freq_q <= '0;
			fend_q <= 1'b1;
		end
	end

	assign res.valid = vld_q;
	assign res.freq_turns = freq_q;
	assign res.frame_end = fend_q;

endmodule

>>> design/iq_instantaneous_frequency.sv
// channel | dir | payload                          | transfer
// iq      | in  | i_sample, q_sample, frame_last   | valid && ready
// result  | out | freq_turns, frame_end            | valid && ready
//
// One sample accepted per cycle while the result side is ready; a sample that
// closes a frame after a step result holds the input until that result is taken.
// From iq transfer to first result a sample passes the pre-rotation register,
// one register per CORDIC step and the result register.
// arst_n clears all valid bits, the pending closing result and frame state.
// A stalled result freezes the whole CORDIC pipeline and drops iq.ready if its tail is valid.
module iq_instantaneous_frequency #(
	parameter int CORDIC_STEPS = iqf_pkg::CORDIC_STEPS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	iqf_iq_if.sink    iq,
	iqf_res_if.source result
);

	logic can_take;
	logic tail_vld;
	iqf_pkg::phase_item_t tail;

	iqf_phase #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_phase (
		.clk     (clk),
		.arst_n  (arst_n),
		.iq      (iq),
		.can_take(can_take),
		.tail_vld(tail_vld),
		.tail    (tail)
	);

	iqf_emit u_emit (
		.clk     (clk),
		.arst_n  (arst_n),
		.tail_vld(tail_vld),
		.tail    (tail),
		.can_take(can_take),
		.res     (result)
	);

	a_end_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.frame_end |-> result.freq_turns == '0)
		else $error("frame end result carries nonzero frequency");

	a_freq_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> ($signed(result.freq_turns) <= 17'sd32768) &&
		($signed(result.freq_turns) >= -17'sd32768))
		else $error("frequency outside half turn");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!iq.ready |-> result.valid && tail_vld)
		else $error("input stalled without pending result");

	a_pipe_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tail_vld && !can_take |=> tail_vld && $stable(tail))
		else $error("pipeline tail lost while stalled");

endmodule

>>> tb/sv/iqf_freq_checker.sv
module iqf_freq_checker #(
	parameter int CORDIC_STEPS = iqf_pkg::CORDIC_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	iqf_iq_if    iq,
	iqf_res_if   result,
	output int   failures,
	output int   outstanding
);

	localparam int STEPS_USED = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;

	localparam logic [31:0] ARCTAN_TURNS [24] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef struct {
		logic signed [16:0] freq_turns;
		logic               frame_end;
	} freq_result_t;

	freq_result_t expected_freq [$];
	logic [15:0]  prev_phase;
	logic         have_prev;

	function automatic logic [15:0] cordic_phase(logic signed [15:0] i_val,
			logic signed [15:0] q_val);
		longint x;
		longint y;
		longint t;
		longint xs;
		longint ys;
		logic [31:0] z;
		z = '0;
		if (i_val == 0 && q_val == 0) begin
			return 16'd0;
		end
		x = longint'(i_val) * 256;
		y = longint'(q_val) * 256;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				z = 32'h4000_0000;
			end else begin
				x = -y;
				y = t;
				z = 32'hC000_0000;
			end
		end
		for (int k = 0; k < STEPS_USED; k++) begin
			xs = x >>> k;
			ys = y >>> k;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + ARCTAN_TURNS[k];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - ARCTAN_TURNS[k];
			end
		end
		z = z + 32'h0000_8000;
		return z[31:16];
	endfunction

	function automatic logic signed [16:0] phase_step(logic [15:0] cur, logic [15:0] prev);
		int d;
		d = int'($signed(cur)) - int'($signed(prev));
		if (d > 32768) begin
			d = d - 65536;
		end else if (d < -32768) begin
			d = d + 65536;
		end
		return d[16:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		freq_result_t exp_res;
		logic [15:0]  phase;
		if (!arst_n) begin
			expected_freq.delete();
			prev_phase = '0;
			have_prev = 1'b0;
			failures = 0;
			outstanding = 0;
		end else begin
			if (iq.valid && iq.ready) begin
				phase = cordic_phase(iq.i_sample, iq.q_sample);
				if (have_prev) begin
					exp_res.freq_turns = phase_step(phase, prev_phase);
					exp_res.frame_end = 1'b0;
					expected_freq.push_back(exp_res);
				end
				prev_phase = phase;
				have_prev = 1'b1;
				if (iq.frame_last) begin
					exp_res.freq_turns = '0;
					exp_res.frame_end = 1'b1;
					expected_freq.push_back(exp_res);
					have_prev = 1'b0;
				end
			end
			if (result.valid && result.ready) begin
				if (expected_freq.size() == 0) begin
					$error("unexpected transfer: freq_turns %0d frame_end %0d",
						result.freq_turns, result.frame_end);
					failures++;
				end else begin
					exp_res = expected_freq.pop_front();
					if (result.freq_turns !== exp_res.freq_turns) begin
						$error("freq_turns: expected %0d, got %0d",
							exp_res.freq_turns, result.freq_turns);
						failures++;
					end
					if (result.frame_end !== exp_res.frame_end) begin
						$error("frame_end: expected %0d, got %0d",
							exp_res.frame_end, result.frame_end);
						failures++;
					end
				end
			end
			outstanding = expected_freq.size();
		end
	end

endmodule

>>> tb/sv/iq_instantaneous_frequency_test.sv
module iq_instantaneous_frequency_test;

	localparam int STEPS = iqf_pkg::CORDIC_STEPS_DEF;
	localparam int SAMPLE_TARGET = 1950;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = STEPS + 30;

	logic clk;
	logic arst_n;
	int   failures;
	int   outstanding;
	int   sent;
	int   cycle_count;
	bit   calm;
	bit   hold_request;

	iqf_iq_if  sample_bus();
	iqf_res_if freq_bus();

	iq_instantaneous_frequency #(
		.CORDIC_STEPS(STEPS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.iq(sample_bus),
		.result(freq_bus)
	);

	iqf_freq_checker #(
		.CORDIC_STEPS(STEPS)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.iq(sample_bus),
		.result(freq_bus),
		.failures(failures),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever begin
			#4 clk = ~clk;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** iq_instantaneous_frequency: FAILED **");
			$finish;
		end
	end

	initial begin
		freq_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				freq_bus.ready <= 1'b0;
				repeat (300) @(negedge clk);
			end else begin
				freq_bus.ready <= calm || ($urandom_range(99) >= 23);
			end
		end
	end

	task automatic push_sample(input logic signed [15:0] i_val,
			input logic signed [15:0] q_val, input logic last);
		int gap;
		if (!calm && $urandom_range(99) < 23) begin
			gap = $urandom_range(1, 4);
			@(negedge clk);
			sample_bus.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		sample_bus.valid <= 1'b1;
		sample_bus.i_sample <= i_val;
		sample_bus.q_sample <= q_val;
		sample_bus.frame_last <= last;
		do begin
			@(posedge clk);
		end while (!sample_bus.ready);
		sent++;
	endtask

	function automatic logic signed [15:0] corner_value();
		case ($urandom_range(4))
			0: return -16'sd32768;
			1: return -16'sd1;
			2: return 16'sd0;
			3: return 16'sd1;
			default: return 16'sd32767;
		endcase
	endfunction

	task automatic random_frame();
		int          len;
		int          shape;
		logic [31:0] r;
		logic        last;
		real         amp;
		real         phi;
		real         dphi;
		len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 24);
		shape = $urandom_range(5);
		amp = real'($urandom_range(1, 32767));
		phi = real'($urandom_range(0, 6283)) / 1000.0;
		dphi = (real'($urandom_range(0, 6400)) - 3200.0) / 1000.0;
		for (int n = 0; n < len; n++) begin
			last = (n == len - 1);
			r = $urandom;
			case (shape)
				0, 1: push_sample(r[15:0], r[31:16], last);
				2: push_sample(16'($signed($urandom_range(0, 6)) - 3),
					16'($signed($urandom_range(0, 6)) - 3), last);
				3: push_sample(corner_value(), corner_value(), last);
				default: begin
					push_sample(16'(int'(amp * $cos(phi))), 16'(int'(amp * $sin(phi))), last);
					phi = phi + dphi;
				end
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		calm = 1'b0;
		hold_request = 1'b0;
		sent = 0;
		cycle_count = 0;
		sample_bus.valid = 1'b0;
		sample_bus.i_sample = '0;
		sample_bus.q_sample = '0;
		sample_bus.frame_last = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		push_sample(16'sd32767, 16'sd0, 1'b0);
		push_sample(-16'sd32768, 16'sd0, 1'b0);
		push_sample(16'sd32767, 16'sd0, 1'b0);
		push_sample(-16'sd1, 16'sd0, 1'b0);
		push_sample(16'sd0, 16'sd0, 1'b0);
		push_sample(16'sd0, 16'sd32767, 1'b0);
		push_sample(16'sd0, -16'sd32768, 1'b0);
		push_sample(-16'sd32768, -16'sd32768, 1'b0);
		push_sample(16'sd32767, 16'sd32767, 1'b0);
		push_sample(-16'sd32768, 16'sd32767, 1'b0);
		push_sample(16'sd32767, -16'sd32768, 1'b0);
		push_sample(-16'sd1, -16'sd1, 1'b1);
		push_sample(16'sd5, -16'sd7, 1'b1);
		push_sample(16'sd0, 16'sd0, 1'b1);
		push_sample(-16'sd1, 16'sd0, 1'b0);
		push_sample(16'sd1, 16'sd0, 1'b0);
		push_sample(-16'sd32768, -16'sd1, 1'b0);
		push_sample(-16'sd32768, 16'sd0, 1'b1);
		push_sample(16'sd21845, -16'sd10923, 1'b0);
		push_sample(-16'sd10923, 16'sd21845, 1'b1);

		@(negedge clk);
		sample_bus.valid <= 1'b0;
		wait (outstanding == 0);

		while (sent < SAMPLE_TARGET) begin
			if (sent >= 400 && sent < 420 && !hold_request) begin
				hold_request = 1'b1;
			end
			calm = (sent >= 700 && sent < 1000);
			if (sent >= 1200 && sent < 1225) begin
				@(negedge clk);
				sample_bus.valid <= 1'b0;
				wait (outstanding == 0);
			end
			random_frame();
		end
		@(negedge clk);
		sample_bus.valid <= 1'b0;

		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0) begin
			$display("** iq_instantaneous_frequency: PASSED **");
		end else begin
			$display("** iq_instantaneous_frequency: FAILED **");
		end
		$finish;
	end

endmodule
